@@ sv/rme_pkg.sv @@
`timescale 1ns / 1ps
package rme_pkg;
  localparam int Steps = 17;
  localparam int VecW = 40;
  localparam int AngW = 20;
  localparam logic signed [AngW-1:0] PiZ = 20'sd205887;
  localparam logic signed [AngW-1:0] PiQ13 = 20'sd25736;
  localparam logic signed [31:0] GainQ30 = 32'sd1768195363;

  typedef logic signed [VecW-1:0] vec_t;
  typedef logic signed [AngW-1:0] ang_t;

  function automatic ang_t atan_lut(input int i);
    case (i)
      0: atan_lut = 20'sd51472;
      1: atan_lut = 20'sd30386;
      2: atan_lut = 20'sd16055;
      3: atan_lut = 20'sd8150;
      4: atan_lut = 20'sd4091;
      5: atan_lut = 20'sd2047;
      6: atan_lut = 20'sd1024;
      7: atan_lut = 20'sd512;
      8: atan_lut = 20'sd256;
      9: atan_lut = 20'sd128;
      10: atan_lut = 20'sd64;
      11: atan_lut = 20'sd32;
      12: atan_lut = 20'sd16;
      13: atan_lut = 20'sd8;
      14: atan_lut = 20'sd4;
      15: atan_lut = 20'sd2;
      16: atan_lut = 20'sd1;
      default: atan_lut = '0;
    endcase
  endfunction

  typedef struct packed {
    logic vld;
    logic zero;
    vec_t x0, y0, x1, y1, x2, y2;
    ang_t z;
  } yaw_cell_t;

  typedef struct packed {
    logic vld;
    logic zero;
    vec_t x, y;
    ang_t z;
  } vec_cell_t;

  function automatic logic signed [15:0] to_q13(input ang_t z);
    ang_t s, q;
    s = z + 20'sd4;
    q = s >>> 3;
    if (q >= PiQ13) q = q - (PiQ13 <<< 1);
    if (q < -PiQ13) q = q + (PiQ13 <<< 1);
    to_q13 = q[15:0];
  endfunction
endpackage

@@ sv/rme_yaw_cell.sv @@
`timescale 1ns / 1ps
module rme_yaw_cell (
  input  logic clk,
  input  logic rst_n,
  input  int unsigned idx,
  input  rme_pkg::yaw_cell_t d,
  output rme_pkg::yaw_cell_t q
);
  import rme_pkg::*;
  yaw_cell_t q_r, q_nxt;
  logic cw;
  always_comb begin
    cw = d.y0 >= 0;
    q_nxt = d;
    if (cw) begin
      q_nxt.x0 = d.x0 + (d.y0 >>> idx); q_nxt.y0 = d.y0 - (d.x0 >>> idx);
      q_nxt.x1 = d.x1 + (d.y1 >>> idx); q_nxt.y1 = d.y1 - (d.x1 >>> idx);
      q_nxt.x2 = d.x2 + (d.y2 >>> idx); q_nxt.y2 = d.y2 - (d.x2 >>> idx);
      q_nxt.z = d.z + atan_lut(idx);
    end else begin
      q_nxt.x0 = d.x0 - (d.y0 >>> idx); q_nxt.y0 = d.y0 + (d.x0 >>> idx);
      q_nxt.x1 = d.x1 - (d.y1 >>> idx); q_nxt.y1 = d.y1 + (d.x1 >>> idx);
      q_nxt.x2 = d.x2 - (d.y2 >>> idx); q_nxt.y2 = d.y2 + (d.x2 >>> idx);
      q_nxt.z = d.z - atan_lut(idx);
    end
    // zero vector: pass through untouched
    if (d.zero) q_nxt = d;
    if (!rst_n) q_nxt.vld = 1'b0;
  end
  always_ff @(posedge clk) begin
    q_r <= q_nxt;
  end
  assign q = q_r;
endmodule

@@ sv/rme_vec_cell.sv @@
`timescale 1ns / 1ps
module rme_vec_cell (
  input  logic clk,
  input  logic rst_n,
  input  int unsigned idx,
  input  rme_pkg::vec_cell_t d,
  output rme_pkg::vec_cell_t q
);
  import rme_pkg::*;
  vec_cell_t q_r, q_nxt;
  always_comb begin
    q_nxt = d;
    if (!d.zero) begin
      if (d.y >= 0) begin
        q_nxt.x = d.x + (d.y >>> idx); q_nxt.y = d.y - (d.x >>> idx);
        q_nxt.z = d.z + atan_lut(idx);
      end else begin
        q_nxt.x = d.x - (d.y >>> idx); q_nxt.y = d.y + (d.x >>> idx);
        q_nxt.z = d.z - atan_lut(idx);
      end
    end
    if (!rst_n) q_nxt.vld = 1'b0;
  end
  always_ff @(posedge clk) begin
    q_r <= q_nxt;
  end
  assign q = q_r;
endmodule

@@ sv/rotation_matrix_to_euler_top.sv @@
`timescale 1ns / 1ps
// path: yaw cordic cells, gain multiply stage, pitch/roll pre-rotation stage, pitch/roll cordic cells, output register
// throughput: one request per cycle, set by the unrolled cordic cell rows
// busy is tied low; the receiver cannot stall, results appear for one cycle
// reset: synchronous active-low rst_n clears all valid flags in the chain
module rotation_matrix_to_euler_top (
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  output logic busy,
  input  logic signed [15:0] in_r00, in_r01, in_r02, in_r10, in_r11, in_r12, in_r20,
  output logic out_valid,
  output logic signed [15:0] out_yaw_angle,
  output logic signed [15:0] out_pitch_angle,
  output logic signed [15:0] out_roll_angle
);
  import rme_pkg::*;
  yaw_cell_t ych [Steps+1];
  vec_cell_t pch [Steps+1];
  vec_cell_t rch [Steps+1];
  logic signed [15:0] yq [Steps+1];
  logic signed [15:0] yq_nxt;
  logic signed [15:0] p_o_r, r_o_r, y_o_r;
  logic vo_r;
  logic signed [15:0] r20_r [Steps];
  logic signed [47:0] gmul_r;
  vec_cell_t p_pre_r, p_pre_nxt;
  vec_cell_t r_pre_r, r_pre_nxt;

  assign busy = 1'b0;

  // pre-rotation by pi into the first cell
  yaw_cell_t y_pre;
  always_comb begin
    vec_t a, b;
    a = {{(VecW-32){in_r00[15]}}, in_r00, 16'h0};
    b = {{(VecW-32){in_r10[15]}}, in_r10, 16'h0};
    y_pre.vld = start;
    y_pre.zero = (in_r00 == 16'sd0) && (in_r10 == 16'sd0);
    y_pre.x0 = a; y_pre.y0 = b;
    y_pre.x1 = {{(VecW-32){in_r11[15]}}, in_r11, 16'h0};
    y_pre.y1 = -{{(VecW-32){in_r01[15]}}, in_r01, 16'h0};
    y_pre.x2 = -{{(VecW-32){in_r02[15]}}, in_r02, 16'h0};
    y_pre.y2 = -{{(VecW-32){in_r12[15]}}, in_r12, 16'h0};
    y_pre.z = '0;
    if (!y_pre.zero && a < 0) begin
      y_pre.z = (b >= 0) ? PiZ : -PiZ;
      y_pre.x0 = -y_pre.x0; y_pre.y0 = -y_pre.y0;
      y_pre.x1 = -y_pre.x1; y_pre.y1 = -y_pre.y1;
      y_pre.x2 = -y_pre.x2; y_pre.y2 = -y_pre.y2;
    end
  end
  assign ych[0] = y_pre;
  always_ff @(posedge clk) r20_r[0] <= in_r20;

  for (genvar i = 0; i < Steps; i++) begin : g_yaw
    rme_yaw_cell u_c (.clk, .rst_n, .idx(i), .d(ych[i]), .q(ych[i+1]));
    if (i > 0) begin : g_d
      always_ff @(posedge clk) r20_r[i] <= r20_r[i-1];
    end
  end

  // gain multiply stage, then pitch/roll pre-rotation stage
  yaw_cell_t ym_r, ym_nxt;
  always_comb begin
    ym_nxt = ych[Steps];
    if (!rst_n) ym_nxt.vld = 1'b0;
  end
  always_ff @(posedge clk) begin
    ym_r <= ym_nxt;
    gmul_r <= -(48'(r20_r[Steps-1]) * 48'(GainQ30));
  end

  function automatic vec_cell_t pre(input logic v, input vec_t x, input vec_t y);
    vec_cell_t c;
    c.vld = v; c.zero = (x == 0) && (y == 0); c.x = x; c.y = y; c.z = '0;
    if (!c.zero && x < 0) begin
      c.z = (y >= 0) ? PiZ : -PiZ; c.x = -x; c.y = -y;
    end
    return c;
  endfunction

  always_comb begin
    p_pre_nxt = pre(ym_r.vld, ym_r.x0, VecW'(gmul_r >>> 14));
    r_pre_nxt = pre(ym_r.vld, ym_r.x1, ym_r.y2);
    if (!rst_n) begin
      p_pre_nxt.vld = 1'b0; r_pre_nxt.vld = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    p_pre_r <= p_pre_nxt;
    r_pre_r <= r_pre_nxt;
    yq[0] <= to_q13(ym_r.z);
  end
  assign pch[0] = p_pre_r;
  assign rch[0] = r_pre_r;

  for (genvar i = 0; i < Steps; i++) begin : g_pr
    rme_vec_cell u_p (.clk, .rst_n, .idx(i), .d(pch[i]), .q(pch[i+1]));
    rme_vec_cell u_r (.clk, .rst_n, .idx(i), .d(rch[i]), .q(rch[i+1]));
    always_ff @(posedge clk) yq[i+1] <= yq[i];
  end
  assign yq_nxt = yq[Steps];

  always_ff @(posedge clk) begin
    p_o_r <= to_q13(pch[Steps].z);
    r_o_r <= to_q13(rch[Steps].z);
    y_o_r <= yq_nxt;
    vo_r <= pch[Steps].vld & rst_n;
  end
  assign out_valid = vo_r;
  assign out_yaw_angle = y_o_r;
  assign out_pitch_angle = p_o_r;
  assign out_roll_angle = r_o_r;
endmodule

@@ sv/rme_checker.sv @@
`timescale 1ns / 1ps
module rme_checker (
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic out_valid,
  input logic signed [15:0] out_yaw_angle,
  input logic signed [15:0] out_pitch_angle,
  input logic signed [15:0] out_roll_angle
);
  a_busy: assert property (@(posedge clk) !busy) else $error("busy raised");
  a_lat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start, 37)) else $error("result without request");
  a_yaw: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_yaw_angle >= -16'sd25736 && out_yaw_angle < 16'sd25736))
    else $error("yaw out of range");
  a_pr: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_pitch_angle >= -16'sd25736 && out_roll_angle >= -16'sd25736))
    else $error("angle out of range");
endmodule

bind rotation_matrix_to_euler_top rme_checker u_chk (.*);

@@ verif/rotation_matrix_to_euler_top_tb.sv @@
`timescale 1ns / 1ps
module rotation_matrix_to_euler_top_tb;
  import rme_pkg::*;

  localparam int LatencyCycles = 37;
  localparam int IdleLimit = 4000;
  localparam int RandomItems = 1150;
  localparam real Pi = 3.14159265358979;

  typedef struct {
    logic signed [15:0] r [7];
    int gap;
    bit drain;
  } matrix_req_t;

  typedef struct {
    logic signed [15:0] yaw;
    logic signed [15:0] pitch;
    logic signed [15:0] roll;
  } euler_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic signed [15:0] in_r00 = '0, in_r01 = '0, in_r02 = '0, in_r10 = '0;
  logic signed [15:0] in_r11 = '0, in_r12 = '0, in_r20 = '0;
  logic out_valid;
  logic signed [15:0] out_yaw_angle, out_pitch_angle, out_roll_angle;

  matrix_req_t pending_reqs [$];
  euler_t expected_angles [$];
  matrix_req_t cur_req;
  euler_t driven_angles;
  bit have_req = 0;
  int gap_left = 0;
  logic start_nxt;
  int errors = 0;
  int idle_cycles = 0;

  rotation_matrix_to_euler_top dut (
    .clk, .rst_n, .start, .busy,
    .in_r00, .in_r01, .in_r02, .in_r10, .in_r11, .in_r12, .in_r20,
    .out_valid, .out_yaw_angle, .out_pitch_angle, .out_roll_angle
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // vectors entry 0 onto the x axis, the others follow the same rotations
  function automatic longint vectorize(inout longint vx [3], inout longint vy [3],
                                       input int n);
    longint z, xs, ys, x, y;
    bit cw;
    z = 0;
    if (vx[0] == 0 && vy[0] == 0) return 0;
    if (vx[0] < 0) begin
      z = (vy[0] >= 0) ? 64'sd205887 : -64'sd205887;
      for (int k = 0; k < n; k++) begin
        vx[k] = -vx[k];
        vy[k] = -vy[k];
      end
    end
    for (int i = 0; i < Steps; i++) begin
      cw = vy[0] >= 0;
      for (int k = 0; k < n; k++) begin
        x = vx[k];
        y = vy[k];
        xs = x >>> i;
        ys = y >>> i;
        vx[k] = cw ? x + ys : x - ys;
        vy[k] = cw ? y - xs : y + xs;
      end
      z += cw ? longint'(atan_lut(i)) : -longint'(atan_lut(i));
    end
    return z;
  endfunction

  function automatic logic signed [15:0] angle_q13(input longint z);
    longint q;
    q = (z + 4) >>> 3;
    if (q >= 25736) q -= 2 * 25736;
    if (q < -25736) q += 2 * 25736;
    return q[15:0];
  endfunction

  function automatic euler_t predict_euler(input matrix_req_t m);
    longint e [7];
    longint vx [3], vy [3];
    longint yz, pz, rz;
    euler_t res;
    for (int k = 0; k < 7; k++) e[k] = longint'(m.r[k]) * 65536;
    // element order: r00 r01 r02 r10 r11 r12 r20
    vx[0] = e[0];  vy[0] = e[3];
    vx[1] = e[4];  vy[1] = -e[1];
    vx[2] = -e[2]; vy[2] = -e[5];
    yz = vectorize(vx, vy, 3);
    vy[0] = (-e[6] * longint'(GainQ30)) >>> 30;
    vx[1] = 0; vy[1] = 0; vx[2] = 0; vy[2] = 0;
    begin
      longint px [3], py [3];
      px[0] = vx[0]; py[0] = vy[0]; px[1] = 0; py[1] = 0; px[2] = 0; py[2] = 0;
      pz = vectorize(px, py, 1);
    end
    res.yaw = angle_q13(yz);
    res.pitch = angle_q13(pz);
    res.roll = 0;
    return res;
  endfunction

  // roll needs the rotated partners, so redo yaw rotation there
  function automatic euler_t predict_all(input matrix_req_t m);
    longint e [7];
    longint vx [3], vy [3], wx [3], wy [3];
    euler_t res;
    res = predict_euler(m);
    for (int k = 0; k < 7; k++) e[k] = longint'(m.r[k]) * 65536;
    vx[0] = e[0];  vy[0] = e[3];
    vx[1] = e[4];  vy[1] = -e[1];
    vx[2] = -e[2]; vy[2] = -e[5];
    void'(vectorize(vx, vy, 3));
    wx[0] = vx[1]; wy[0] = vy[2];
    wx[1] = 0; wy[1] = 0; wx[2] = 0; wy[2] = 0;
    res.roll = angle_q13(vectorize(wx, wy, 1));
    return res;
  endfunction

  function automatic matrix_req_t make_req(input int a, b, c, d, f, g, h);
    matrix_req_t m;
    m.r[0] = 16'(a); m.r[1] = 16'(b); m.r[2] = 16'(c); m.r[3] = 16'(d);
    m.r[4] = 16'(f); m.r[5] = 16'(g); m.r[6] = 16'(h);
    m.gap = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 17) : 0;
    m.drain = 0;
    return m;
  endfunction

  function automatic int q14(input real v);
    return $rtoi(v * 16384.0 + (v >= 0 ? 0.5 : -0.5));
  endfunction

  function automatic matrix_req_t rotation_req();
    real y, p, r, cy, sy, cp, sp, cr, sr;
    y = ($urandom_range(0, 1 << 20) / real'(1 << 20) * 2.0 - 1.0) * Pi;
    p = ($urandom_range(0, 1 << 20) / real'(1 << 20) * 2.0 - 1.0) * Pi;
    r = ($urandom_range(0, 1 << 20) / real'(1 << 20) * 2.0 - 1.0) * Pi;
    cy = $cos(y); sy = $sin(y); cp = $cos(p); sp = $sin(p); cr = $cos(r); sr = $sin(r);
    return make_req(q14(cy * cp), q14(cy * sp * sr - sy * cr), q14(cy * sp * cr + sy * sr),
                    q14(sy * cp), q14(sy * sp * sr + cy * cr), q14(sy * sp * cr - cy * sr),
                    q14(-sp));
  endfunction

  // driver
  always @(posedge clk) begin
    start_nxt = start;
    if (!rst_n) begin
      start_nxt = 1'b0;
    end else begin
      if (start && !busy) begin
        expected_angles.push_back(driven_angles);
        start_nxt = 1'b0;
      end
      if (!start_nxt) begin
        if (!have_req && pending_reqs.size() > 0) begin
          cur_req = pending_reqs.pop_front();
          have_req = 1;
          gap_left = cur_req.gap;
        end
        if (have_req) begin
          if (gap_left > 0) begin
            gap_left--;
          end else if (!cur_req.drain || expected_angles.size() == 0) begin
            in_r00 <= cur_req.r[0]; in_r01 <= cur_req.r[1]; in_r02 <= cur_req.r[2];
            in_r10 <= cur_req.r[3]; in_r11 <= cur_req.r[4]; in_r12 <= cur_req.r[5];
            in_r20 <= cur_req.r[6];
            driven_angles = predict_all(cur_req);
            start_nxt = 1'b1;
            have_req = 0;
          end
        end
      end
    end
    start <= start_nxt;
  end

  // monitor
  always @(posedge clk) begin
    euler_t exp_a;
    if (rst_n && out_valid) begin
      if (expected_angles.size() == 0) begin
        $display("%0t: unexpected result yaw=%0d pitch=%0d roll=%0d", $time,
                 out_yaw_angle, out_pitch_angle, out_roll_angle);
        errors++;
      end else begin
        exp_a = expected_angles.pop_front();
        if (out_yaw_angle !== exp_a.yaw) begin
          $display("%0t: yaw expected %0d actual %0d", $time, exp_a.yaw, out_yaw_angle);
          errors++;
        end
        if (out_pitch_angle !== exp_a.pitch) begin
          $display("%0t: pitch expected %0d actual %0d", $time, exp_a.pitch,
                   out_pitch_angle);
          errors++;
        end
        if (out_roll_angle !== exp_a.roll) begin
          $display("%0t: roll expected %0d actual %0d", $time, exp_a.roll, out_roll_angle);
          errors++;
        end
      end
    end
  end

  // watchdog on cycles with no request or result moving
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
        $display("rotation_matrix_to_euler_top_tb: errors");
        $finish;
      end
    end
  end

  initial begin
    matrix_req_t m;
    int sel;
    pending_reqs.push_back(make_req(0, 0, 0, 0, 0, 0, 0));
    pending_reqs.push_back(make_req(16384, 0, 0, 0, 16384, 0, 0));
    pending_reqs.push_back(make_req(16384, 16384, 16384, 16384, 16384, 16384, 16384));
    pending_reqs.push_back(make_req(-16384, -16384, -16384, -16384, -16384, -16384, -16384));
    pending_reqs.push_back(make_req(32767, 32767, 32767, 32767, 32767, 32767, 32767));
    pending_reqs.push_back(make_req(-32768, -32768, -32768, -32768, -32768, -32768, -32768));
    pending_reqs.push_back(make_req(-32768, 32767, -32768, 32767, -32768, 32767, -32768));
    pending_reqs.push_back(make_req(32767, -32768, 32767, -32768, 32767, -32768, 32767));
    // yaw of pi wraps to minus pi
    pending_reqs.push_back(make_req(-16384, 0, 0, 0, -16384, 0, 0));
    pending_reqs.push_back(make_req(-16384, 0, 0, -1, -16384, 0, 0));
    pending_reqs.push_back(make_req(0, 0, 0, 16384, 0, 0, 0));
    pending_reqs.push_back(make_req(0, 0, 0, -16384, 0, 0, 0));
    // zero yaw vector, gimbal lock
    pending_reqs.push_back(make_req(0, 0, 16384, 0, 16384, 0, -16384));
    pending_reqs.push_back(make_req(0, 16384, 0, 0, 0, -16384, 16384));
    pending_reqs.push_back(make_req(0, -32768, 32767, 0, 32767, -32768, 32767));
    pending_reqs.push_back(make_req(0, 0, 0, 0, -16384, 0, 0));
    pending_reqs.push_back(make_req(-16384, 0, 0, 0, 16384, 0, 1));
    pending_reqs.push_back(make_req(11585, -11585, 0, 11585, 11585, 0, 0));
    for (int i = 0; i < RandomItems; i++) begin
      sel = $urandom_range(0, 99);
      if (sel < 65) begin
        m = rotation_req();
      end else if (sel < 85) begin
        m = rotation_req();
        for (int k = 0; k < 7; k++) begin
          m.r[k] = 16'(int'(m.r[k]) + int'($urandom_range(0, 63)) - 32);
        end
      end else begin
        m = make_req($urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
      end
      if (i == RandomItems / 2) m.drain = 1;
      pending_reqs.push_back(m);
    end
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    wait (pending_reqs.size() == 0 && !have_req && !start && expected_angles.size() == 0);
    repeat (LatencyCycles + 5) @(posedge clk);
    if (errors == 0) begin
      $display("rotation_matrix_to_euler_top_tb: clean");
    end else begin
      $display("rotation_matrix_to_euler_top_tb: errors");
    end
    $finish;
  end
endmodule
